FILE: hw/rtl/mtrv_pkg.sv
// Shared types and constants for the Modbus TCP request validator.
`timescale 1ns / 1ps
package mtrv_pkg;

    localparam int POS_W = 9;
    localparam logic [POS_W-1:0] POS_MAX = 9'd511;

    // Verdict codes
    localparam logic [2:0] VERDICT_DROP       = 3'd0;
    localparam logic [2:0] VERDICT_READ       = 3'd1;
    localparam logic [2:0] VERDICT_WR_SINGLE  = 3'd2;
    localparam logic [2:0] VERDICT_WR_MULTI   = 3'd3;
    localparam logic [2:0] VERDICT_EXCEPTION  = 3'd4;

    // Exception codes
    localparam logic [1:0] EXC_NONE     = 2'd0;
    localparam logic [1:0] EXC_FUNCTION = 2'd1;
    localparam logic [1:0] EXC_ADDRESS  = 2'd2;
    localparam logic [1:0] EXC_VALUE    = 2'd3;

    // Function codes
    localparam logic [7:0] FC_COIL_READ     = 8'h01;
    localparam logic [7:0] FC_READ_DISCRETE = 8'h02;
    localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
    localparam logic [7:0] FC_READ_INPUT    = 8'h04;
    localparam logic [7:0] FC_WRITE_COIL    = 8'h05;
    localparam logic [7:0] FC_WRITE_REG     = 8'h06;
    localparam logic [7:0] FC_WRITE_COILS   = 8'h0F;
    localparam logic [7:0] FC_WRITE_REGS    = 8'h10;
    localparam logic [7:0] FC_EXC_FLAG      = 8'h80;

    // Data areas
    localparam logic [1:0] AREA_COILS    = 2'd0;
    localparam logic [1:0] AREA_DISCRETE = 2'd1;
    localparam logic [1:0] AREA_INPUT    = 2'd2;
    localparam logic [1:0] AREA_HOLDING  = 2'd3;

    // Limits
    localparam logic [15:0] MAX_READ_BITS  = 16'd2000;
    localparam logic [15:0] MAX_READ_REGS  = 16'd125;
    localparam logic [15:0] MAX_WRITE_BITS = 16'd1968;
    localparam logic [15:0] MAX_WRITE_REGS = 16'd123;
    localparam logic [15:0] LEN_MIN        = 16'd2;
    localparam logic [15:0] LEN_MAX        = 16'd254;
    localparam logic [15:0] COIL_ON        = 16'hFF00;
    localparam logic [7:0]  UNIT_ANY_LOW   = 8'h00;
    localparam logic [7:0]  UNIT_ANY_HIGH  = 8'hFF;
    localparam logic [16:0] ADDR_SPACE     = 17'h10000;

    // Register byte addresses
    localparam logic [2:0] ADDR_UNIT_ADDRESS = 3'd0;

    // Frame fields as they stand once the current byte is captured.
    typedef struct packed {
        logic [15:0]      transaction_word;
        logic [15:0]      protocol_word;
        logic [15:0]      length_word;
        logic [7:0]       unit_byte;
        logic [7:0]       function_byte;
        logic [15:0]      start_word;
        logic [15:0]      count_word;
        logic [7:0]       byte_count_field;
        logic [POS_W-1:0] frame_bytes;
    } frame_fields_t;

    typedef struct packed {
        logic [2:0]       verdict;
        logic [1:0]       exception_code;
        logic [7:0]       function_code;
        logic [15:0]      transaction_id;
        logic [7:0]       unit_echo;
        logic [15:0]      start_address;
        logic [10:0]      item_count;
        logic [15:0]      write_value;
        logic [1:0]       data_area;
        logic             bit_access;
        logic [POS_W-1:0] frame_bytes;
    } result_t;

endpackage

FILE: hw/rtl/mtrv_capture.sv
// Byte counter and header field capture for one request frame.
`timescale 1ns / 1ps
module mtrv_capture (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  xfer,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output mtrv_pkg::frame_fields_t fields
);
    import mtrv_pkg::*;

    logic [POS_W-1:0] byte_position_reg;
    frame_fields_t    stored_reg;
    frame_fields_t    fields_next;

    always_comb
    begin
        fields_next = stored_reg;
        case (byte_position_reg)
            9'd0:  fields_next.transaction_word[15:8] = data_byte;
            9'd1:  fields_next.transaction_word[7:0]  = data_byte;
            9'd2:  fields_next.protocol_word[15:8]    = data_byte;
            9'd3:  fields_next.protocol_word[7:0]     = data_byte;
            9'd4:  fields_next.length_word[15:8]      = data_byte;
            9'd5:  fields_next.length_word[7:0]       = data_byte;
            9'd6:  fields_next.unit_byte              = data_byte;
            9'd7:  fields_next.function_byte          = data_byte;
            9'd8:  fields_next.start_word[15:8]       = data_byte;
            9'd9:  fields_next.start_word[7:0]        = data_byte;
            9'd10: fields_next.count_word[15:8]       = data_byte;
            9'd11: fields_next.count_word[7:0]        = data_byte;
            9'd12: fields_next.byte_count_field       = data_byte;
            default: ;
        endcase
        fields_next.frame_bytes = (byte_position_reg == POS_MAX) ? POS_MAX
                                : byte_position_reg + 9'd1;
    end

    assign fields = fields_next;

    // Everything returns to zero after the final byte of a frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            stored_reg        <= '0;
        end
        else if (xfer)
        begin
            if (last_byte)
            begin
                byte_position_reg <= '0;
                stored_reg        <= '0;
            end
            else
            begin
                byte_position_reg <= fields_next.frame_bytes;
                stored_reg        <= fields_next;
            end
        end
    end

endmodule

FILE: hw/rtl/mtrv_check.sv
// Frame checks and request decode that form the verdict.
`timescale 1ns / 1ps
module mtrv_check (
    input  mtrv_pkg::frame_fields_t fields,
    input  logic [7:0]              unit_address,
    output mtrv_pkg::result_t       result
);
    import mtrv_pkg::*;

    logic [15:0] frame16;
    logic        frame_bad;
    logic [7:0]  fc;
    logic [15:0] count;
    logic [16:0] range_sum;
    logic        range_ok;
    logic        bits;
    logic [15:0] dlen;
    logic [15:0] frame_want;
    logic [1:0]  area;
    logic [1:0]  exc;
    logic [2:0]  ok_verdict;

    always_comb
    begin
        frame16   = {7'd0, fields.frame_bytes};
        frame_bad = (frame16 < 16'd8) || (fields.protocol_word != 16'd0)
                 || (fields.length_word < LEN_MIN) || (fields.length_word > LEN_MAX)
                 || (frame16 != fields.length_word + 16'd6)
                 || ((fields.unit_byte != unit_address)
                     && (fields.unit_byte != UNIT_ANY_LOW)
                     && (fields.unit_byte != UNIT_ANY_HIGH));

        fc        = fields.function_byte;
        count     = fields.count_word;
        range_sum = {1'b0, fields.start_word} + {1'b0, count};
        range_ok  = (range_sum <= ADDR_SPACE);

        case (fc) inside
            FC_COIL_READ, FC_WRITE_COIL, FC_WRITE_COILS: area = AREA_COILS;
            FC_READ_DISCRETE: area = AREA_DISCRETE;
            FC_READ_INPUT:    area = AREA_INPUT;
            default:          area = AREA_HOLDING;
        endcase

        bits       = 1'b0;
        dlen       = '0;
        frame_want = '0;
        exc        = EXC_NONE;
        ok_verdict = VERDICT_EXCEPTION;

        case (fc) inside
            FC_COIL_READ, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT:
            begin
                bits       = (fc == FC_COIL_READ) || (fc == FC_READ_DISCRETE);
                ok_verdict = VERDICT_READ;
                if ((frame16 != 16'd12) || (count == 16'd0)
                    || (bits && count > MAX_READ_BITS)
                    || (!bits && count > MAX_READ_REGS))
                    exc = EXC_VALUE;
                else if (!range_ok)
                    exc = EXC_ADDRESS;
            end
            FC_WRITE_COIL, FC_WRITE_REG:
            begin
                bits       = (fc == FC_WRITE_COIL);
                ok_verdict = VERDICT_WR_SINGLE;
                if ((frame16 != 16'd12)
                    || (bits && count != COIL_ON && count != 16'd0))
                    exc = EXC_VALUE;
            end
            FC_WRITE_COILS, FC_WRITE_REGS:
            begin
                bits       = (fc == FC_WRITE_COILS);
                ok_verdict = VERDICT_WR_MULTI;
                // Coil data is packed eight to a byte, registers take two bytes.
                dlen       = bits ? ((count + 16'd7) >> 3) : {count[14:0], 1'b0};
                frame_want = dlen + 16'd13;
                if ((frame16 < 16'd13) || (count == 16'd0)
                    || (bits && count > MAX_WRITE_BITS)
                    || (!bits && count > MAX_WRITE_REGS))
                    exc = EXC_VALUE;
                else if (!range_ok)
                    exc = EXC_ADDRESS;
                else if (({8'd0, fields.byte_count_field} != dlen)
                         || (frame16 != frame_want))
                    exc = EXC_VALUE;
            end
            default:
                exc = EXC_FUNCTION;
        endcase

        result             = '0;
        result.frame_bytes = fields.frame_bytes;
        if (!frame_bad)
        begin
            result.transaction_id = fields.transaction_word;
            result.unit_echo      = fields.unit_byte;
            if (exc != EXC_NONE)
            begin
                result.verdict        = VERDICT_EXCEPTION;
                result.exception_code = exc;
                result.function_code  = fc | FC_EXC_FLAG;
            end
            else
            begin
                result.verdict       = ok_verdict;
                result.function_code = fc;
                result.start_address = fields.start_word;
                result.data_area     = area;
                result.bit_access    = bits;
                if (ok_verdict == VERDICT_WR_SINGLE)
                begin
                    result.item_count  = 11'd1;
                    result.write_value = count;
                end
                else
                    result.item_count = count[10:0];
            end
        end
    end

endmodule

FILE: hw/rtl/modbus_tcp_request_validator_core.sv
// Output: the verdict is registered when the final byte transfers and is shown from the next cycle.
// Throughput: one byte per cycle; a byte is taken whenever the result slot is
// empty or being emptied in the same cycle.
// Reset: rst_n clears the byte counter, captured fields and output valid, and
// sets unit_address to 1.
`timescale 1ns / 1ps
module modbus_tcp_request_validator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  verdict,
    output logic [1:0]  exception_code,
    output logic [7:0]  function_code,
    output logic [15:0] transaction_id,
    output logic [7:0]  unit_echo,
    output logic [15:0] start_address,
    output logic [10:0] item_count,
    output logic [15:0] write_value,
    output logic [1:0]  data_area,
    output logic        bit_access,
    output logic [8:0]  frame_bytes,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mtrv_pkg::*;

    logic          in_xfer;
    logic [7:0]    unit_address_reg;
    frame_fields_t fields;
    result_t       result;
    result_t       result_reg;
    logic          out_valid_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;
    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_UNIT_ADDRESS) ? {24'd0, unit_address_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            unit_address_reg <= 8'd1;
        else if (psel && penable && pwrite && (paddr == ADDR_UNIT_ADDRESS))
            unit_address_reg <= pwdata[7:0];
    end

    mtrv_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .xfer      (in_xfer),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .fields    (fields)
    );

    mtrv_check u_check (
        .fields       (fields),
        .unit_address (unit_address_reg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer && last_byte)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && last_byte)
            result_reg <= result;
    end

    assign out_valid      = out_valid_reg;
    assign verdict        = result_reg.verdict;
    assign exception_code = result_reg.exception_code;
    assign function_code  = result_reg.function_code;
    assign transaction_id = result_reg.transaction_id;
    assign unit_echo      = result_reg.unit_echo;
    assign start_address  = result_reg.start_address;
    assign item_count     = result_reg.item_count;
    assign write_value    = result_reg.write_value;
    assign data_area      = result_reg.data_area;
    assign bit_access     = result_reg.bit_access;
    assign frame_bytes    = result_reg.frame_bytes;

endmodule

FILE: hw/rtl/mtrv_checker.sv
// Port-level checks for the request validator, bound to the top level.
`timescale 1ns / 1ps
module mtrv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  verdict,
    input logic [1:0]  exception_code,
    input logic [7:0]  function_code,
    input logic [15:0] transaction_id,
    input logic [8:0]  frame_bytes
);
    import mtrv_pkg::*;

    // A held result keeps its verdict, function code and frame length until the transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict)
            && $stable(function_code) && $stable(frame_bytes))
    else $error("held result changed before transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_byte |=> out_valid)
    else $error("final byte gave no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input stalled with an empty result slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == VERDICT_DROP |->
            exception_code == EXC_NONE && function_code == 8'd0 && transaction_id == 16'd0)
    else $error("dropped frame carries fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == VERDICT_EXCEPTION |->
            function_code[7] && exception_code != EXC_NONE)
    else $error("exception result lacks its code or flag");

endmodule

bind modbus_tcp_request_validator_core mtrv_checker u_mtrv_checker (.*);
